// File: rtl/huf_pkg.sv
`default_nettype none

package huf_pkg;

  localparam int MAX_NODES = 256;
  localparam int KEY_BITS  = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_DECODE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [7:0] CH_LEFT  = 8'h30;
  localparam logic [7:0] CH_RIGHT = 8'h31;
  localparam logic [7:0] CH_END   = 8'h32;

  localparam logic [1:0] KIND_SYMBOL  = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  node_symbol;
    logic [15:0] node_order;
    logic [7:0]  code_char;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } out_item_t;

  typedef struct packed {
    logic [7:0]          symbol;
    logic [KEY_BITS-1:0] key;
    logic [NODE_W-1:0]   left;
    logic [NODE_W-1:0]   right;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/huf_ram.sv
`default_nettype none

module huf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/huf_seq.sv
`default_nettype none

module huf_seq
  import huf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output res_t                       res,
  input  wire logic                  res_take,
  output stat_t                      stat,
  output logic                       wr_en,
  output logic      [NODE_W-1:0]     wr_addr,
  output node_t                      wr_data,
  output logic                       rd_en,
  output logic      [NODE_W-1:0]     rd_addr,
  input  wire logic [NODE_BITS-1:0]  rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DESC,
    S_STEP,
    S_LEAF,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [NODE_W-1:0]   walk_r, walk_nxt;
  logic [NODE_W-1:0]   at_r, at_nxt;
  logic [NODE_W-1:0]   fresh_r, fresh_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                dir_r, dir_nxt;
  logic [NODE_W-1:0]   next_r, next_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [7:0]          sym_r, sym_nxt;

  node_t             rnode;
  logic              accept;
  logic [NODE_W-1:0] child;
  logic              go_left;

  assign rnode    = node_t'(rd_data);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign go_left  = (key_r <= rnode.key);

  assign res.valid       = (state_r == S_EMIT);
  assign res.item.kind   = kind_r;
  assign res.item.symbol = sym_r;
  assign stat.total      = total_r;

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    walk_nxt  = walk_r;
    at_nxt    = at_r;
    fresh_nxt = fresh_r;
    key_nxt   = key_r;
    dir_nxt   = dir_r;
    next_nxt  = next_r;
    kind_nxt  = kind_r;
    sym_nxt   = sym_r;
    wr_en     = 1'b0;
    wr_addr   = at_r;
    wr_data   = rnode;
    rd_en     = 1'b0;
    rd_addr   = at_r;
    child     = dir_r ? rnode.right : rnode.left;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_LOAD: begin
              if (total_r == CNT_W'(MAX_NODES)) begin
                kind_nxt  = KIND_FULL;
                sym_nxt   = 8'd0;
                state_nxt = S_EMIT;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = total_r[NODE_W-1:0];
                wr_data.symbol = in_data.node_symbol;
                wr_data.key    = in_data.node_order[KEY_BITS-1:0];
                wr_data.left   = '0;
                wr_data.right  = '0;
                total_nxt     = total_r + 1'b1;
                if (total_r != '0) begin
                  fresh_nxt = total_r[NODE_W-1:0];
                  key_nxt   = in_data.node_order[KEY_BITS-1:0];
                  at_nxt    = '0;
                  rd_en     = 1'b1;
                  rd_addr   = '0;
                  state_nxt = S_DESC;
                end
              end
            end
            MODE_DECODE: begin
              if (in_data.code_char == CH_END) begin
                walk_nxt  = '0;
                kind_nxt  = KIND_END;
                sym_nxt   = 8'd0;
                state_nxt = S_EMIT;
              end else if (in_data.code_char == CH_LEFT ||
                           in_data.code_char == CH_RIGHT) begin
                if (total_r == '0 || {1'b0, walk_r} >= total_r) begin
                  walk_nxt  = '0;
                  kind_nxt  = KIND_MISSING;
                  sym_nxt   = 8'd0;
                  state_nxt = S_EMIT;
                end else begin
                  dir_nxt   = (in_data.code_char == CH_RIGHT);
                  rd_en     = 1'b1;
                  rd_addr   = walk_r;
                  state_nxt = S_STEP;
                end
              end
            end
            MODE_CLEAR: begin
              total_nxt = '0;
              walk_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DESC: begin
        child = go_left ? rnode.left : rnode.right;
        if (child == '0) begin
          wr_en   = 1'b1;
          wr_addr = at_r;
          wr_data = rnode;
          if (go_left) begin
            wr_data.left = fresh_r;
          end else begin
            wr_data.right = fresh_r;
          end
          state_nxt = S_IDLE;
        end else begin
          at_nxt  = child;
          rd_en   = 1'b1;
          rd_addr = child;
        end
      end
      S_STEP: begin
        if (child == '0 || {1'b0, child} >= total_r) begin
          walk_nxt  = '0;
          kind_nxt  = KIND_MISSING;
          sym_nxt   = 8'd0;
          state_nxt = S_EMIT;
        end else begin
          next_nxt  = child;
          rd_en     = 1'b1;
          rd_addr   = child;
          state_nxt = S_LEAF;
        end
      end
      S_LEAF: begin
        if (rnode.left == '0 && rnode.right == '0) begin
          walk_nxt  = '0;
          kind_nxt  = KIND_SYMBOL;
          sym_nxt   = rnode.symbol;
          state_nxt = S_EMIT;
        end else begin
          walk_nxt  = next_r;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      walk_r  <= walk_nxt;
    end
    at_r    <= at_nxt;
    fresh_r <= fresh_nxt;
    key_r   <= key_nxt;
    dir_r   <= dir_nxt;
    next_r  <= next_nxt;
    kind_r  <= kind_nxt;
    sym_r   <= sym_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/huffman_tree_bit_decoder_core.sv
// Huffman code-tree decoder. Items enter on in_valid/in_stall/in_data and
// results leave on out_valid/out_stall/out_data; an item is taken at a clock
// edge where its valid is high and its stall is low.
// A load item appends a node to the table and links it into the tree by
// ordered descent, a clear item empties the table, and a decode item moves
// the walk one step on '0' or '1', or ends the message on '2'.
// Each item yields at most one result: a decoded symbol, end of message,
// a missing child or a full table.
// One item is in work at a time. A load into an empty table only writes
// the root. Any other load that fits descends the tree from the root,
// and the single node memory is read once per level passed. A load into
// a full table writes nothing and only gives its result. A decode step
// reads the walk node, then its child, and gives a result at a leaf or
// a missing child. A clear or an ignored character gives no result.
// Results sit in an output register, so the next item is taken while a
// result still waits; a second result waits inside the block until that
// register is free, and in_stall stays high meanwhile.
// Reset empties the table and puts the walk at the root; the node memory
// itself is not cleared, and no entry is read before it is loaded.
`default_nettype none

module huffman_tree_bit_decoder_core
  import huf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  res_t              res;
  stat_t             stat;
  logic              res_take;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  node_t             wr_data;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic [NODE_BITS-1:0] rd_data;

  huf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res      (res),
    .res_take (res_take),
    .stat     (stat),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  huf_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (NODE_BITS'(wr_data)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_take  = res.valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_data_r <= res.item;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.total <= CNT_W'(MAX_NODES))
    else $error("node count above table size");

  a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_SYMBOL) |-> out_data.symbol == 8'd0)
    else $error("symbol not zero on a non-symbol item");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_take) |=> (res.valid && $stable(res.item)))
    else $error("pending result lost or changed");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.mode == MODE_CLEAR) |=> stat.total == '0)
    else $error("clear did not empty the table");

endmodule

`default_nettype wire
